// ----- design/hhlp_pkg.sv -----
// ----------------------------------------------------------------------------
// hhlp_pkg
// Types, character codes and the header-name table shared by the header
// length parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hhlp_pkg;

	// character codes
	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_COLON = 8'h3A;

	// length of the matched header name and its reset-time default body length
	localparam logic [3:0]  NAME_LEN            = 4'd14;
	localparam logic [31:0] DEFAULT_BODY_LENGTH = 32'd1000000;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_BODY   = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		VS_SKIP   = 3'b001,
		VS_DIGITS = 3'b010,
		VS_DONE   = 3'b100
	} value_state_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_HDR_END = 2'd1,
		KIND_BODY    = 2'd2,
		KIND_IGNORED = 2'd3
	} byte_kind_t;

	// per-line parse state
	typedef struct packed {
		logic         at_line_start;
		logic         name_is_empty;
		logic         in_value;
		logic         name_ended;
		logic [3:0]   name_match_pos;
		logic         name_mismatch;
		value_state_t value_state;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		at_line_start:  1'b1,
		name_is_empty:  1'b0,
		in_value:       1'b0,
		name_ended:     1'b0,
		name_match_pos: 4'd0,
		name_mismatch:  1'b0,
		value_state:    VS_SKIP
	};

	// events raised by a line-terminating byte
	typedef struct packed {
		logic header_end;
		logic take_length;
	} line_event_t;

	// characters of the Content-Length header name
	function automatic logic [7:0] name_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = CHR_NUL;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- design/hhlp_if.sv -----
// ----------------------------------------------------------------------------
// hhlp channels
// Valid/ready channels for the byte input, the parse result and the
// default-length configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_message;

	modport source (output valid, output data_byte, output new_message, input ready);
	modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

interface hhlp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  byte_kind;
	logic        body_last;
	logic        length_declared;
	logic [31:0] body_len;
	logic [7:0]  data_out;

	modport source (
		output valid, output byte_kind, output body_last, output length_declared,
		output body_len, output data_out, input ready
	);
	modport sink (
		input valid, input byte_kind, input body_last, input length_declared,
		input body_len, input data_out, output ready
	);
endinterface

interface hhlp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/http_header_length_parser.sv -----
// Pipeline: an accepted byte is held in the input register, and its result is
// then registered in the result register, where it waits until it is taken.
// Throughput: one byte per cycle; the input register fills when it is empty or
// advancing, and both advance whenever the result register is empty or taken.
// Reset: clears all parse state to the start of a header and sets the default
// body length to 1000000; the configuration port is always ready.
// ----------------------------------------------------------------------------
// http_header_length_parser
// Streams HTTP response bytes, finds the header end and the Content-Length
// value, and tags each byte as header, header end, body or ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module http_header_length_parser #(
	parameter int LENGTH_BITS = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hhlp_cfg_if.sink   cfg,
	hhlp_in_if.sink    byte_in,
	hhlp_out_if.source result
);
	import hhlp_pkg::*;

	// configuration
	logic [31:0] dflt_len_q;

	// input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       newmsg_s1;

	// result stage
	logic        valid_s2;
	byte_kind_t  kind_s2;
	logic        last_s2;
	logic        seen_s2;
	logic [31:0] body_len_s2;
	logic [7:0]  data_s2;

	// parse state
	phase_t                 phase_q;
	line_state_t            line_q;
	logic                   prev_cr_q;
	logic [LENGTH_BITS-1:0] accum_q;
	logic [LENGTH_BITS-1:0] declared_q;
	logic                   seen_q;
	logic [LENGTH_BITS-1:0] remaining_q;

	// state as seen by the current byte (restart applied)
	phase_t                 phase_cur;
	line_state_t            line_cur;
	logic                   prev_cr_cur;
	logic [LENGTH_BITS-1:0] accum_cur;
	logic [LENGTH_BITS-1:0] declared_cur;
	logic                   seen_cur;
	logic [LENGTH_BITS-1:0] remaining_cur;

	// next state
	phase_t                 phase_d;
	line_state_t            line_d;
	logic                   prev_cr_d;
	logic [LENGTH_BITS-1:0] accum_d;
	logic [LENGTH_BITS-1:0] declared_d;
	logic                   seen_d;
	logic [LENGTH_BITS-1:0] remaining_d;
	byte_kind_t             kind_d;
	logic                   last_d;
	logic [31:0]            body_len_d;

	// line parser outputs
	line_state_t            line_nxt;
	logic                   prev_cr_nxt;
	logic [LENGTH_BITS-1:0] accum_nxt;
	line_event_t            evt;

	logic advance;
	logic fire;

	// handshake control
	assign advance      = !valid_s2 || result.ready;
	assign fire         = valid_s1 && advance;
	assign byte_in.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	// hold the default body length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_len_q <= DEFAULT_BODY_LENGTH;
		end else if (cfg.valid && cfg.ready) begin
			dflt_len_q <= cfg.data;
		end
	end

	// capture an input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			data_s1   <= byte_in.data_byte;
			newmsg_s1 <= byte_in.new_message;
		end
	end

	// apply a message restart ahead of the byte
	assign phase_cur     = newmsg_s1 ? PH_HEADER : phase_q;
	assign line_cur      = newmsg_s1 ? LINE_CLEAR : line_q;
	assign prev_cr_cur   = newmsg_s1 ? 1'b0 : prev_cr_q;
	assign accum_cur     = newmsg_s1 ? '0 : accum_q;
	assign declared_cur  = newmsg_s1 ? '0 : declared_q;
	assign seen_cur      = newmsg_s1 ? 1'b0 : seen_q;
	assign remaining_cur = newmsg_s1 ? '0 : remaining_q;

	hhlp_line_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_line_parser (
		.data_byte   (data_s1),
		.line_cur    (line_cur),
		.prev_cr_cur (prev_cr_cur),
		.accum_cur   (accum_cur),
		.line_nxt    (line_nxt),
		.prev_cr_nxt (prev_cr_nxt),
		.accum_nxt   (accum_nxt),
		.evt         (evt)
	);

	// message phase sequencing
	always_comb begin
		phase_d     = phase_cur;
		line_d      = line_cur;
		prev_cr_d   = prev_cr_cur;
		accum_d     = accum_cur;
		declared_d  = declared_cur;
		seen_d      = seen_cur;
		remaining_d = remaining_cur;
		kind_d      = KIND_IGNORED;
		last_d      = 1'b0;
		unique case (phase_cur)
			PH_HEADER: begin
				kind_d    = KIND_HEADER;
				line_d    = line_nxt;
				prev_cr_d = prev_cr_nxt;
				accum_d   = accum_nxt;
				if (evt.take_length) begin
					declared_d = accum_cur;
					seen_d     = 1'b1;
				end
				if (evt.header_end) begin
					kind_d      = KIND_HDR_END;
					declared_d  = seen_cur ? declared_cur : LENGTH_BITS'(dflt_len_q);
					remaining_d = declared_d;
					phase_d     = (declared_d == '0) ? PH_DONE : PH_BODY;
				end
			end
			PH_BODY: begin
				kind_d = KIND_BODY;
				if (remaining_cur != '0) begin
					remaining_d = remaining_cur - LENGTH_BITS'(1);
				end
				if (remaining_d == '0) begin
					last_d  = 1'b1;
					phase_d = PH_DONE;
				end
			end
			default: begin
				kind_d  = KIND_IGNORED;
				phase_d = PH_DONE;
			end
		endcase
		body_len_d = (phase_d == PH_HEADER) ? 32'd0 : 32'(declared_d);
	end

	// commit parse state on each processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			line_q      <= LINE_CLEAR;
			prev_cr_q   <= 1'b0;
			accum_q     <= '0;
			declared_q  <= '0;
			seen_q      <= 1'b0;
			remaining_q <= '0;
		end else if (fire) begin
			phase_q     <= phase_d;
			line_q      <= line_d;
			prev_cr_q   <= prev_cr_d;
			accum_q     <= accum_d;
			declared_q  <= declared_d;
			seen_q      <= seen_d;
			remaining_q <= remaining_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_s2     <= kind_d;
			last_s2     <= last_d;
			seen_s2     <= seen_d;
			body_len_s2 <= body_len_d;
			data_s2     <= data_s1;
		end
	end

	assign result.valid           = valid_s2;
	assign result.byte_kind       = kind_s2;
	assign result.body_last       = last_s2;
	assign result.length_declared = seen_s2;
	assign result.body_len        = body_len_s2;
	assign result.data_out        = data_s2;

	// checks
	a_last_is_body: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.body_last |-> result.byte_kind == KIND_BODY)
		else $error("body_last flagged on a non-body byte");

	a_header_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.byte_kind == KIND_HEADER) |-> result.body_len == 32'd0)
		else $error("body length shown before header end");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_s1))
		else $error("input stage lost a stalled transaction");

	a_name_pos: assert property (@(posedge clk) disable iff (!arst_n)
		line_q.name_match_pos <= NAME_LEN)
		else $error("name match position out of range");

endmodule

`default_nettype wire

// ----- design/hhlp_line_parser.sv -----
// ----------------------------------------------------------------------------
// hhlp_line_parser
// Next-state logic for one header byte: line ending, name/value split,
// Content-Length name match and saturating decimal value accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module hhlp_line_parser #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic [7:0]             data_byte,
	input  wire hhlp_pkg::line_state_t  line_cur,
	input  wire logic                   prev_cr_cur,
	input  wire logic [LENGTH_BITS-1:0] accum_cur,
	output      hhlp_pkg::line_state_t  line_nxt,
	output      logic                   prev_cr_nxt,
	output      logic [LENGTH_BITS-1:0] accum_nxt,
	output      hhlp_pkg::line_event_t  evt
);
	import hhlp_pkg::*;

	logic                   colon_split;
	logic                   line_end;
	logic                   is_digit;
	logic                   is_blank;
	logic [3:0]             digit_val;
	logic [LENGTH_BITS+3:0] accum_x10;
	logic                   accum_ovf;

	// classify the byte
	assign colon_split = (data_byte == CHR_COLON) && !line_cur.in_value;
	assign line_end    = !colon_split && (data_byte == CHR_LF) && prev_cr_cur;
	assign is_digit    = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);
	assign is_blank    = (data_byte == CHR_SPACE) ||
		((data_byte >= CHR_TAB) && (data_byte <= CHR_CR));
	assign digit_val   = is_digit ? data_byte[3:0] : 4'd0;

	// accum * 10 + digit, with overflow past the length width detected
	assign accum_x10 = ({4'd0, accum_cur} << 3) + ({4'd0, accum_cur} << 1) +
		(LENGTH_BITS+4)'(digit_val);
	assign accum_ovf = |accum_x10[LENGTH_BITS+3:LENGTH_BITS];

	// advance the line state
	always_comb begin
		line_nxt    = line_cur;
		prev_cr_nxt = (data_byte == CHR_CR);
		accum_nxt   = accum_cur;
		evt         = '0;
		if (line_end) begin
			prev_cr_nxt = 1'b0;
			if (line_cur.name_is_empty) begin
				evt.header_end = 1'b1;
			end else begin
				evt.take_length = line_cur.in_value && !line_cur.name_mismatch &&
					(line_cur.name_match_pos == NAME_LEN);
				line_nxt  = LINE_CLEAR;
				accum_nxt = '0;
			end
		end else begin
			// a lone CR at line start followed by anything else is part of the name
			if (prev_cr_cur && line_cur.name_is_empty && !line_cur.in_value &&
				!line_cur.name_ended) begin
				line_nxt.name_is_empty = 1'b0;
			end
			if (colon_split) begin
				if (line_cur.at_line_start) begin
					line_nxt.name_is_empty = 1'b1;
				end
				line_nxt.in_value    = 1'b1;
				line_nxt.value_state = VS_SKIP;
				accum_nxt            = '0;
			end else if (!line_cur.in_value) begin
				if (line_cur.at_line_start &&
					((data_byte == CHR_CR) || (data_byte == CHR_NUL))) begin
					line_nxt.name_is_empty = 1'b1;
				end
				if (!line_cur.name_ended) begin
					if (data_byte == CHR_NUL) begin
						line_nxt.name_ended = 1'b1;
					end else if ((line_cur.name_match_pos < NAME_LEN) &&
						(data_byte == name_char(line_cur.name_match_pos))) begin
						line_nxt.name_match_pos = line_cur.name_match_pos + 4'd1;
					end else begin
						line_nxt.name_mismatch = 1'b1;
					end
				end
			end else begin
				unique case (line_cur.value_state)
					VS_SKIP: begin
						if (is_digit) begin
							accum_nxt            = LENGTH_BITS'(digit_val);
							line_nxt.value_state = VS_DIGITS;
						end else if ((data_byte == CHR_NUL) || !is_blank) begin
							line_nxt.value_state = VS_DONE;
						end
					end
					VS_DIGITS: begin
						if (!is_digit) begin
							line_nxt.value_state = VS_DONE;
						end else if (accum_ovf) begin
							accum_nxt = '1;
						end else begin
							accum_nxt = accum_x10[LENGTH_BITS-1:0];
						end
					end
					default: begin
					end
				endcase
			end
			line_nxt.at_line_start = 1'b0;
		end
	end

endmodule

`default_nettype wire
